// File: design/circular_deque_buffer_defines.svh
// Assertion macros shared by the circular deque buffer RTL.
`ifndef CIRCULAR_DEQUE_BUFFER_DEFINES_SVH
`define CIRCULAR_DEQUE_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define CDB_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cdb: invariant violated");

// Consequence must hold in the cycle after the antecedent.
`define CDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdb: next-cycle check failed");

`else

`define CDB_ASSERT_HOLDS(label, clk, rst_n, cond)
`define CDB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/cdb_pkg.sv
// Types and constants of the circular deque buffer.
package cdb_pkg;

    // Field widths of the transfer payloads
    localparam int OP_W       = 3;
    localparam int VALUE_W    = 32;
    localparam int OFFSET_W   = 10;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;

    // Parameter defaults
    localparam int DEFAULT_DEPTH         = 1024;
    localparam int DEFAULT_ELEMENT_WIDTH = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_AT    = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE_AT   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [VALUE_W-1:0]  element_value;
        logic [OFFSET_W-1:0] offset;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_out_item;

endpackage

// File: design/circular_deque_buffer.sv
// Top level of the circular deque buffer: index control, storage and result staging.

// Double-ended ring buffer of DEPTH words held in one single-port RAM. Each
// transfer carries one operation (push or pop at either end, read or write at
// an offset from the front); each gives exactly one result with the read
// data, a status and the count held afterwards. The block takes one operation
// per cycle while the output is not stalled. Stage A captures the item together
// with its offset quotient; as the item leaves stage A the offset is reduced
// modulo DEPTH, the indices are updated and the single RAM access is performed,
// with the status and count registered in stage C; the output register then
// registers the result. The single RAM port is what bounds the rate at one
// operation per cycle. Entries are not cleared after reset; reading an entry
// never written returns whatever the RAM holds.
`include "circular_deque_buffer_defines.svh"

module circular_deque_buffer
    import cdb_pkg::*;
#(
    parameter int DEPTH         = DEFAULT_DEPTH,
    parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PROD_W = OFFSET_W + 32;
    localparam logic [63:0] RECIP64 = ((64'd1 << 32) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam logic [PROD_W-1:0] RECIP = RECIP64[PROD_W-1:0];
    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Pipeline control
    logic o_adv, c_free, a_adv, a_free;

    // Stage A: item and offset quotient
    logic                r_a_valid;
    t_in_item            r_a_item;
    logic [OFFSET_W-1:0] r_a_quot;
    logic [PROD_W-1:0]   quot_prod;

    // Index state
    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_back, n_back;
    logic [CNT_W-1:0] r_count, n_count;

    // Access decode
    logic [31:0]         off_sub;
    logic [31:0]         off_red32;
    logic [IDX_W-1:0]    off_red;
    logic [IDX_W:0]      off_sum;
    logic [IDX_W-1:0]    off_slot;
    logic [IDX_W-1:0]    front_dn, back_up, back_dn, front_up;
    logic [IDX_W-1:0]    ram_addr;
    logic                ram_en, ram_we;
    logic [63:0]         wval64;
    logic [ELEMENT_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [STATUS_W-1:0] acc_status;
    logic                acc_is_read;
    logic                is_full, is_empty;

    // Stage C: access done, waiting for read data
    logic                r_c_valid;
    logic                r_c_is_read;
    logic [STATUS_W-1:0] r_c_status;
    logic [CNT_W-1:0]    r_c_count;
    logic [63:0]         rd64, cnt64;

    // Output register
    logic      r_o_valid;
    t_out_item r_o_item;

    // Advance conditions, from the output back to the input
    assign o_adv  = !r_o_valid || !i_out_stall;
    assign c_free = !r_c_valid || o_adv;
    assign a_adv  = r_a_valid && c_free;
    assign a_free = !r_a_valid || c_free;
    assign o_in_stall = !a_free;

    // Offset quotient by reciprocal multiplication
    assign quot_prod = PROD_W'(i_in_item.offset) * RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && i_in_valid) begin
            r_a_item <= i_in_item;
            r_a_quot <= quot_prod[PROD_W-1:32];
        end
    end

    // Offset slot: remainder of offset, added to front, wrapped once
    always_comb begin
        off_sub   = 32'(r_a_quot) * 32'(DEPTH);
        off_red32 = 32'(r_a_item.offset) - off_sub;
        off_red   = off_red32[IDX_W-1:0];
        off_sum   = {1'b0, r_front} + {1'b0, off_red};
        if (off_sum >= DEPTH_X) begin
            off_slot = IDX_W'(off_sum - DEPTH_X);
        end else begin
            off_slot = off_sum[IDX_W-1:0];
        end
    end

    // Neighbor slots around the ring
    assign front_dn = (r_front == '0) ? IDX_LAST : r_front - 1'b1;
    assign front_up = (r_front == IDX_LAST) ? '0 : r_front + 1'b1;
    assign back_dn  = (r_back == '0) ? IDX_LAST : r_back - 1'b1;
    assign back_up  = (r_back == IDX_LAST) ? '0 : r_back + 1'b1;

    assign is_full  = (r_count == CNT_FULL);
    assign is_empty = (r_count == '0);

    assign wval64    = 64'(r_a_item.element_value);
    assign ram_wdata = wval64[ELEMENT_WIDTH-1:0];

    // Operation decode: index updates and the single RAM access
    always_comb begin
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        ram_addr    = off_slot;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        acc_status  = ST_DONE;
        acc_is_read = 1'b0;
        case (r_a_item.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (is_full) begin
                    acc_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    ram_en  = 1'b1;
                    ram_we  = 1'b1;
                    if (is_empty) begin
                        n_back   = r_front;
                        ram_addr = r_front;
                    end else if (r_a_item.operation == OP_PUSH_FRONT) begin
                        n_front  = front_dn;
                        ram_addr = front_dn;
                    end else begin
                        n_back   = back_up;
                        ram_addr = back_up;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (is_empty) begin
                    acc_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    if (r_a_item.operation == OP_POP_FRONT) begin
                        n_front = front_up;
                    end else begin
                        n_back = back_dn;
                    end
                end
            end
            OP_READ_AT: begin
                ram_en      = 1'b1;
                acc_is_read = 1'b1;
            end
            OP_WRITE_AT: begin
                ram_en = 1'b1;
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (a_adv) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    // Entry storage
    cdb_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en && a_adv),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Stage C: result metadata, read data arrives from the RAM register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= a_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_c_is_read <= acc_is_read;
            r_c_status  <= acc_status;
            r_c_count   <= n_count;
        end
    end

    assign rd64  = 64'(ram_rdata);
    assign cnt64 = 64'(r_c_count);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_adv) begin
            r_o_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_valid && o_adv) begin
            r_o_item.read_value <= r_c_is_read ? rd64[VALUE_W-1:0] : '0;
            r_o_item.status     <= r_c_status;
            r_o_item.count      <= cnt64[COUNT_W-1:0];
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

    // Checks
    `CDB_ASSERT_HOLDS(a_single_front_back, i_clk, i_rst_n,
        (r_count != CNT_W'(1)) || (r_front == r_back))
    `CDB_ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n,
        (r_count <= CNT_FULL) && (is_full ? !(a_adv && ram_we && !is_empty &&
        (r_a_item.operation == OP_PUSH_FRONT || r_a_item.operation == OP_PUSH_BACK))
        : 1'b1))
    `CDB_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n,
        a_adv && !is_full &&
        (r_a_item.operation == OP_PUSH_FRONT || r_a_item.operation == OP_PUSH_BACK),
        r_count == $past(r_count) + 1'b1)
    `CDB_ASSERT_NEXT(a_refused_holds, i_clk, i_rst_n,
        a_adv && (acc_status != ST_DONE),
        (r_front == $past(r_front)) && (r_back == $past(r_back)) &&
        (r_count == $past(r_count)))

endmodule

// File: design/cdb_ram.sv
// Generic single-port synchronous RAM with registered read data.
module cdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
